>>> hdl/plpp_pkg.sv
// ----------------------------------------------------------------------------
// plpp_pkg
// Shared types and constants for the line-plane projection pipeline.
// ----------------------------------------------------------------------------
package plpp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_PPM      = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  // Denominator magnitude below this (1e-6 in Q.30) means a parallel line
  localparam logic [48:0] DEN_MIN = 49'd1074;

  // Quotient bits produced by the divider, and the quotient cap 2^40
  localparam int QB = 41;
  localparam logic [QB-1:0] QUOT_CAP = {1'b1, {(QB-1){1'b0}}};

  // Side data that rides along with each divider lane
  typedef struct packed {
    logic signed [31:0] eye;
    logic               neg;
    logic               oos;
  } lane_side_t;

endpackage

>>> hdl/plpp_div_lane.sv
// ----------------------------------------------------------------------------
// plpp_div_lane
// One coordinate lane: pipelined restoring divider, quotient cap and the
// final saturated subtraction from the eye coordinate.
// ----------------------------------------------------------------------------
module plpp_div_lane (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [79:0]              dvd,
  input  logic [48:0]              den,
  input  plpp_pkg::lane_side_t     side,
  output logic signed [31:0]       hit
);

  localparam int QB = plpp_pkg::QB;

  logic [48:0]          rem   [0:QB];
  logic [QB-1:0]        low   [0:QB];
  logic [QB-1:0]        quo   [0:QB];
  logic [48:0]          den_s [0:QB];
  logic                 ovf_s [0:QB];
  plpp_pkg::lane_side_t side_s [0:QB];

  // Load: overflow check on the top bits, seed the remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_s[0]  <= {10'd0, dvd[79:QB]} >= den;
      rem[0]    <= {10'd0, dvd[79:QB]};
      low[0]    <= dvd[QB-1:0];
      quo[0]    <= '0;
      den_s[0]  <= den;
      side_s[0] <= side;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [49:0] sh;
    logic [49:0] diff;
    logic        ge;
    assign sh   = {rem[k-1], low[k-1][QB-1]};
    assign diff = sh - {1'b0, den_s[k-1]};
    assign ge   = sh >= {1'b0, den_s[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]    <= ge ? diff[48:0] : sh[48:0];
        low[k]    <= {low[k-1][QB-2:0], 1'b0};
        quo[k]    <= {quo[k-1][QB-2:0], ge};
        den_s[k]  <= den_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
        side_s[k] <= side_s[k-1];
      end
    end
  end

  // Cap the quotient
  logic [QB-1:0]        q_cap;
  plpp_pkg::lane_side_t side_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      q_cap  <= (ovf_s[QB] || (quo[QB] > plpp_pkg::QUOT_CAP)) ?
                plpp_pkg::QUOT_CAP : quo[QB];
      side_c <= side_s[QB];
    end
  end

  // Subtract from the eye coordinate and saturate
  logic signed [42:0] qs;
  logic signed [42:0] h_wide;
  assign qs     = side_c.neg ? -$signed({2'b00, q_cap}) : $signed({2'b00, q_cap});
  assign h_wide = {{11{side_c.eye[31]}}, side_c.eye} - qs;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_c.oos) begin
        hit <= '0;
      end else if (h_wide > 43'sd2147483647) begin
        hit <= 32'sh7FFFFFFF;
      end else if (h_wide < -43'sd2147483648) begin
        hit <= 32'sh80000000;
      end else begin
        hit <= h_wide[31:0];
      end
    end
  end

endmodule

>>> hdl/plpp_pixel.sv
// ----------------------------------------------------------------------------
// plpp_pixel
// Maps a Q15.16 coordinate to a clamped pixel index in two stages.
// ----------------------------------------------------------------------------
module plpp_pixel #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [31:0]    coord,
  input  logic [15:0]           ppm,
  input  logic [12:0]           size,
  output logic [PIXEL_BITS-1:0] pixel
);

  localparam logic [13:0] TOP = 14'((1 << PIXEL_BITS) - 1);

  // Scale
  logic signed [48:0] prod;
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= coord * $signed({1'b0, ppm});
    end
  end

  // Truncate toward zero, center and clamp
  logic [48:0]        mag;
  logic signed [34:0] off;
  logic [12:0]        sz;
  logic signed [34:0] pos;
  logic [13:0]        lim;
  logic [13:0]        res;

  always_comb begin
    mag = prod[48] ? 49'(-prod) : prod;
    off = prod[48] ? -$signed({2'b00, mag[48:16]}) : $signed({2'b00, mag[48:16]});
    sz  = (size == 13'd0) ? 13'd1 : size;
    pos = $signed({23'd0, sz[12:1]}) + off;
    lim = ({1'b0, sz} - 14'd1 < TOP) ? {1'b0, sz} - 14'd1 : TOP;
    if (pos < 0) begin
      res = '0;
    end else if (pos > $signed({21'd0, lim})) begin
      res = lim;
    end else begin
      res = pos[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel <= PIXEL_BITS'(res);
    end
  end

endmodule

>>> hdl/line_plane_project_to_pixel_unit.sv
// ----------------------------------------------------------------------------
// line_plane_project_to_pixel_unit
// Intersects the eye-target line with the display plane and maps the hit to
// an image pixel.
// ----------------------------------------------------------------------------
// Fully pipelined: one projection enters per cycle while the output is not
// stalled, and each passes through 51 register stages. The stages are five of
// dot products and wide multiplies, one divider load stage, the 41-stage
// restoring divider (one quotient bit per stage), two capping/saturation
// stages and two pixel mapping stages. A stall on the output side freezes the
// whole pipeline; bubbles are not compressed. Configuration is read live and
// must only change while the pipeline is empty.
module line_plane_project_to_pixel_unit #(
  parameter int PIXEL_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z (32 bits each)
  input  logic [191:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // hit_x, hit_y, hit_z (32 each), pixel_x, pixel_y, out_of_sight, zero fill
  output logic [((96 + 2*PIXEL_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_data
);

  localparam int OUT_W = ((96 + 2*PIXEL_BITS + 1 + 7) / 8) * 8;
  localparam int LAT   = 5 + plpp_pkg::QB + 3 + 2;

  // Configuration registers
  logic signed [15:0] nrm [0:2];
  logic [15:0]        ppm;
  logic [12:0]        img_w;
  logic [12:0]        img_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= 16'sd0;
      nrm[1] <= 16'sd0;
      nrm[2] <= 16'sd16384;
      ppm    <= 16'd5000;
      img_w  <= 13'd640;
      img_h  <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        plpp_pkg::REG_NORMAL_X: nrm[0] <= cfg_data;
        plpp_pkg::REG_NORMAL_Y: nrm[1] <= cfg_data;
        plpp_pkg::REG_NORMAL_Z: nrm[2] <= cfg_data;
        plpp_pkg::REG_PPM:      ppm    <= cfg_data;
        plpp_pkg::REG_WIDTH:    img_w  <= cfg_data[12:0];
        plpp_pkg::REG_HEIGHT:   img_h  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves when the output is free or taken
  logic adv;
  logic [LAT-1:0] vld;
  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: split the beat, form the direction
  logic signed [31:0] e1 [0:2];
  logic signed [32:0] d1 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= s_tdata[32*i +: 32];
        d1[i] <= $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]})
               - $signed({s_tdata[32*(i+3)+31], s_tdata[32*(i+3) +: 32]});
      end
    end
  end

  // Stage 2: per-axis products with the normal
  logic signed [31:0] e2 [0:2];
  logic signed [32:0] d2 [0:2];
  logic signed [47:0] pe [0:2];
  logic signed [48:0] pd [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e2[i] <= e1[i];
        d2[i] <= d1[i];
        pe[i] <= e1[i] * nrm[i];
        pd[i] <= d1[i] * nrm[i];
      end
    end
  end

  // Stage 3: dot products
  logic signed [31:0] e3 [0:2];
  logic signed [32:0] d3 [0:2];
  logic signed [49:0] num3;
  logic signed [50:0] den3;
  always_ff @(posedge clk) begin
    if (adv) begin
      e3   <= e2;
      d3   <= d2;
      num3 <= 50'(pe[0]) + 50'(pe[1]) + 50'(pe[2]);
      den3 <= 51'(pd[0]) + 51'(pd[1]) + 51'(pd[2]);
    end
  end

  // Stage 4: magnitudes, signs and split partial products
  logic [49:0] num_abs;
  logic [50:0] den_abs;
  assign num_abs = num3[49] ? 50'(-num3) : num3;
  assign den_abs = den3[50] ? 51'(-den3) : den3;

  logic [48:0]          den4;
  logic [56:0]          pl4 [0:2];
  logic [56:0]          ph4 [0:2];
  plpp_pkg::lane_side_t side4 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      den4 <= den_abs[48:0];
      for (int i = 0; i < 3; i++) begin
        logic [32:0] dm;
        dm = d3[i][32] ? 33'(-d3[i]) : d3[i];
        pl4[i]        <= dm * num_abs[23:0];
        ph4[i]        <= dm * num_abs[47:24];
        side4[i].eye  <= e3[i];
        side4[i].neg  <= d3[i][32] ^ num3[49] ^ den3[50];
        side4[i].oos  <= den_abs[48:0] < plpp_pkg::DEN_MIN;
      end
    end
  end

  // Stage 5: assemble the dividends
  logic [48:0]          den5;
  logic [79:0]          dvd5  [0:2];
  plpp_pkg::lane_side_t side5 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      den5 <= den4;
      for (int i = 0; i < 3; i++) begin
        dvd5[i]  <= 80'({ph4[i], 24'd0} + {24'd0, pl4[i]});
        side5[i] <= side4[i];
      end
    end
  end

  // Divider lanes
  logic signed [31:0] hit [0:2];
  logic               oos_l [0:plpp_pkg::QB+2];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    plpp_div_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .dvd  (dvd5[i]),
      .den  (den5),
      .side (side5[i]),
      .hit  (hit[i])
    );
  end

  // Carry the flag alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      oos_l[0] <= side5[0].oos;
      for (int k = 1; k <= plpp_pkg::QB + 2; k++) begin
        oos_l[k] <= oos_l[k-1];
      end
    end
  end

  // Pixel mapping, hit delayed to match
  logic [PIXEL_BITS-1:0] px;
  logic [PIXEL_BITS-1:0] py;
  plpp_pixel #(.PIXEL_BITS(PIXEL_BITS)) u_pix_x (
    .clk (clk), .adv (adv), .coord (hit[0]), .ppm (ppm), .size (img_w), .pixel (px)
  );
  plpp_pixel #(.PIXEL_BITS(PIXEL_BITS)) u_pix_y (
    .clk (clk), .adv (adv), .coord (hit[1]), .ppm (ppm), .size (img_h), .pixel (py)
  );

  logic [95:0] hit_d1;
  logic [95:0] hit_d2;
  logic        oos_d1;
  logic        oos_d2;
  always_ff @(posedge clk) begin
    if (adv) begin
      hit_d1 <= {hit[2], hit[1], hit[0]};
      hit_d2 <= hit_d1;
      oos_d1 <= oos_l[plpp_pkg::QB+2];
      oos_d2 <= oos_d1;
    end
  end

  assign m_tdata = OUT_W'({oos_d2, py, px, hit_d2});

  // A stall freezes every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during stall");

  // An accepted beat enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat lost");

  // Parallel line returns the plane origin
  a_oos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && oos_d2 |-> hit_d2 == '0)
    else $error("out of sight with nonzero hit");

endmodule

>>> bench/line_plane_project_to_pixel_unit_tb.sv
// ----------------------------------------------------------------------------
// line_plane_project_to_pixel_unit_tb
// Self-checking bench for the line-plane projection unit. A predictor computes
// the expected hit point and pixel for every accepted beat and checks the
// output stream in order, across several plane, scale and image settings,
// under random source and sink idling and one long sink hold-off.
// ----------------------------------------------------------------------------
module line_plane_project_to_pixel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = 12;
  localparam int OW = ((96 + 2*PB + 1 + 7) / 8) * 8;
  localparam int LAT = 51;
  localparam int LIMIT = 2000000;
  // index with no register behind it
  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk = 0, rst = 1;
  logic [191:0] s_tdata = '0;
  logic s_tvalid = 0, s_tready;
  logic [OW-1:0] m_tdata;
  logic m_tvalid, m_tready = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  line_plane_project_to_pixel_unit #(.PIXEL_BITS(PB)) DUT (.*);

  // plane and image settings mirrored from register writes
  logic signed [15:0] nrm [3];
  logic [15:0] ppm;
  logic [12:0] img_w, img_h;

  logic [191:0] pending_points [$];
  logic [OW-1:0] expected_hits [$];
  int errors = 0, src_idle = 35, snk_idle = 55, hold_cycles = 0, cycles = 0, n_hits = 0;
  int n_oos = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [PB-1:0] pixel_of(input logic signed [31:0] hit,
                                             input logic [12:0] size);
    logic signed [63:0] p, off, pos, sz;
    p = 64'(hit) * $signed({48'd0, ppm});
    off = mag(p) >> 16;
    if (p < 0) off = -off;
    sz = size == 0 ? 1 : size;
    pos = sz / 2 + off;
    if (pos < 0) pos = 0;
    if (pos > sz - 1) pos = sz - 1;
    if (pos > (1 << PB) - 1) pos = (1 << PB) - 1;
    return pos[PB-1:0];
  endfunction

  function automatic logic [OW-1:0] project_point(input logic [191:0] pt);
    logic signed [63:0] e [3];
    logic signed [63:0] d [3];
    logic signed [31:0] h [3];
    logic signed [63:0] num, den, v;
    logic [127:0] prod, q;
    logic neg, oos;
    num = 0; den = 0;
    for (int i = 0; i < 3; i++) begin
      e[i] = $signed(pt[32*i +: 32]);
      d[i] = e[i] - 64'($signed(pt[32*(i+3) +: 32]));
      num += e[i] * 64'(nrm[i]);
      den += d[i] * 64'(nrm[i]);
    end
    oos = mag(den) < 1074;
    for (int i = 0; i < 3; i++) begin
      if (oos) h[i] = 0;
      else begin
        neg = ((d[i] < 0) != (num < 0)) != (den < 0);
        prod = 128'(mag(d[i])) * 128'(mag(num));
        q = prod / 128'(mag(den));
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        v = e[i] - (neg ? -$signed(q[63:0]) : $signed(q[63:0]));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        h[i] = v[31:0];
      end
    end
    return OW'({oos, pixel_of(h[1], img_h), pixel_of(h[0], img_w), h[2], h[1], h[0]});
  endfunction

  // driver: offer queued points with random gaps, hold data until accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_hits.push_back(project_point(s_tdata));
        void'(pending_points.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= src_idle) begin
          s_tvalid <= 1;
          s_tdata <= pending_points[0];
        end else s_tvalid <= 0;
      end
    end
  end

  // monitor: random sink stalls plus a counted long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_hits.size() == 0) begin
          errors <= errors + 1;
          $display("%t unexpected beat %h", $realtime, m_tdata);
        end else begin
          if (m_tdata !== expected_hits[0]) begin
            errors <= errors + 1;
            $display("%t mismatch exp %h act %h", $realtime, expected_hits[0], m_tdata);
          end
          if (expected_hits[0][96+2*PB]) n_oos <= n_oos + 1;
          void'(expected_hits.pop_front());
        end
        n_hits <= n_hits + 1;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 0;
      end else m_tready <= $urandom_range(99) >= snk_idle;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      plpp_pkg::REG_NORMAL_X: nrm[0] = val;
      plpp_pkg::REG_NORMAL_Y: nrm[1] = val;
      plpp_pkg::REG_NORMAL_Z: nrm[2] = val;
      plpp_pkg::REG_PPM:      ppm = val;
      plpp_pkg::REG_WIDTH:    img_w = val[12:0];
      plpp_pkg::REG_HEIGHT:   img_h = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || s_tvalid || expected_hits.size() > 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic add_rand(input int n);
    logic [31:0] c [6];
    for (int k = 0; k < n; k++) begin
      foreach (c[j]) c[j] = rand_coord();
      // make some lines parallel to the x-y plane (the display plane when the normal is along z)
      if ($urandom_range(9) == 0) c[5] = c[2];
      pending_points.push_back({c[5], c[4], c[3], c[2], c[1], c[0]});
    end
  endtask

  initial begin
    nrm[0] = 0; nrm[1] = 0; nrm[2] = 16384; ppm = 5000; img_w = 640; img_h = 480;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: extremes, parallel line, typical eye/target geometry
    pending_points.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_points.push_back({32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    pending_points.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h80000000, 32'h80000000, 32'h80000000});
    pending_points.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd3, 32'sd5});
    pending_points.push_back({-32'sd65536, 32'sd13107, -32'sd6554,
                              32'sd65536, 32'sd0, 32'sd0});
    pending_points.push_back({-32'sd131072, 32'sd70000, 32'sd90000,
                              32'sd131072, -32'sd5000, 32'sd1000});
    pending_points.push_back({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    add_rand(10);
    drain();
    // zero normal, zero scale, zero image size, unknown index
    write_reg(plpp_pkg::REG_NORMAL_Z, 16'd0); write_reg(plpp_pkg::REG_PPM, 16'd0);
    write_reg(plpp_pkg::REG_WIDTH, 16'd0); write_reg(plpp_pkg::REG_HEIGHT, 16'd0);
    write_reg(REG_NONE, 16'hffff);
    add_rand(6);
    drain();
    // extreme normals, largest scale and image
    write_reg(plpp_pkg::REG_NORMAL_X, 16'hc000); write_reg(plpp_pkg::REG_NORMAL_Y, 16'h4000);
    write_reg(plpp_pkg::REG_NORMAL_Z, 16'h4000); write_reg(plpp_pkg::REG_PPM, 16'hffff);
    write_reg(plpp_pkg::REG_WIDTH, 16'd4096); write_reg(plpp_pkg::REG_HEIGHT, 16'd4096);
    add_rand(250);
    drain();
    // swap idling; stall sink long while source keeps offering
    src_idle = 55; snk_idle = 35;
    write_reg(plpp_pkg::REG_NORMAL_X, 16'h1234); write_reg(plpp_pkg::REG_NORMAL_Y, 16'hfedc);
    write_reg(plpp_pkg::REG_NORMAL_Z, 16'h2d41); write_reg(plpp_pkg::REG_PPM, 16'd1);
    write_reg(plpp_pkg::REG_WIDTH, 16'd1); write_reg(plpp_pkg::REG_HEIGHT, 16'd4095);
    add_rand(250);
    hold_cycles <= 300;
    drain();
    // no idling, random settings
    src_idle = 0; snk_idle = 0;
    write_reg(plpp_pkg::REG_NORMAL_X, 16'($urandom_range(32768) - 16384));
    write_reg(plpp_pkg::REG_NORMAL_Y, 16'($urandom_range(32768) - 16384));
    write_reg(plpp_pkg::REG_NORMAL_Z, 16'($urandom_range(32768) - 16384));
    write_reg(plpp_pkg::REG_PPM, 16'($urandom_range(1, 65535)));
    write_reg(plpp_pkg::REG_WIDTH, 16'($urandom_range(1, 4096)));
    write_reg(plpp_pkg::REG_HEIGHT, 16'($urandom_range(1, 4096)));
    add_rand(320);
    drain();
    $display("checked %0d projections, %0d out of sight, over five register settings",
             n_hits, n_oos);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
